@@ sv/qmt_pkg.sv @@
package qmt_pkg;

    localparam int CMD_W     = 2;
    localparam int IN_KEY_W  = 32;
    localparam int STATUS_W  = 2;
    localparam int OUT_KEY_W = 32;
    localparam int CNT_OUT_W = 5;
    localparam int TDATA_W   = 40;

    localparam logic [CMD_W-1:0] CMD_DEQUEUE = 2'd0;
    localparam logic [CMD_W-1:0] CMD_PROMOTE = 2'd1;
    localparam logic [CMD_W-1:0] CMD_APPEND  = 2'd2;

    typedef enum logic [STATUS_W-1:0] {
        STS_OK        = 2'd0,
        STS_EMPTY     = 2'd1,
        STS_NOT_FOUND = 2'd2,
        STS_FULL      = 2'd3
    } t_status;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DEQ_RD,
        ST_DEQ_DATA,
        ST_APPEND,
        ST_SRCH_RD,
        ST_SRCH_CMP,
        ST_MV_RD,
        ST_MV_WR,
        ST_TAIL_WR,
        ST_FINISH
    } t_state;

    typedef struct packed {
        logic [CMD_W-1:0]    cmd;
        logic [IN_KEY_W-1:0] key;
    } t_req;

    typedef struct packed {
        t_status              status;
        logic [OUT_KEY_W-1:0] key;
        logic [CNT_OUT_W-1:0] count;
    } t_result;

    typedef struct packed {
        logic idle;
        logic done;
    } t_ctl_sts;

endpackage

@@ sv/qmt_ram.sv @@
module qmt_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

@@ sv/qmt_ctrl.sv @@
module qmt_ctrl
    import qmt_pkg::*;
#(
    parameter int DEPTH = 16,
    parameter int KEY_W = 32
) (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_start,
    input  t_req     i_req,
    input  logic     i_out_free,
    output t_ctl_sts o_sts,
    output t_result  o_res
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam int SW = CW + 1;

    t_state           r_state, n_state;
    logic [AW-1:0]    r_head, n_head;
    logic [CW-1:0]    r_count, n_count;
    logic [CW-1:0]    r_pos, n_pos;
    logic [AW-1:0]    r_slot, n_slot;
    logic [KEY_W-1:0] r_key, n_key;
    t_status          r_status, n_status;
    logic [OUT_KEY_W-1:0] r_out_key, n_out_key;

    logic                  w_we;
    logic [AW-1:0]         w_waddr;
    logic [KEY_W-1:0]      w_wdata;
    logic [AW-1:0]         w_raddr;
    logic [KEY_W-1:0]      w_rdata;
    logic [KEY_W+31:0]     w_key_wide;
    logic [KEY_W+31:0]     w_rd_wide;
    logic [CW+CNT_OUT_W-1:0] w_cnt_wide;
    logic [SW-1:0]         w_tail_sum;
    logic [AW-1:0]         w_tail_slot;
    logic [AW-1:0]         w_slot_inc;
    logic                  w_last_pos;
    logic                  w_key_hit;

    qmt_ram #(
        .WIDTH(KEY_W),
        .DEPTH(DEPTH)
    ) u_ram (
        .i_clk  (i_clk),
        .i_we   (w_we),
        .i_waddr(w_waddr),
        .i_wdata(w_wdata),
        .i_raddr(w_raddr),
        .o_rdata(w_rdata)
    );

    assign w_key_wide = {{KEY_W{1'b0}}, i_req.key};
    assign w_rd_wide  = {32'b0, w_rdata};
    assign w_cnt_wide = {{CNT_OUT_W{1'b0}}, r_count};

    // slot of the first free position behind the tail
    assign w_tail_sum  = SW'(r_head) + SW'(r_count);
    assign w_tail_slot = (w_tail_sum >= SW'(DEPTH)) ? AW'(w_tail_sum - SW'(DEPTH))
                                                    : AW'(w_tail_sum);

    assign w_slot_inc = (r_slot == AW'(DEPTH - 1)) ? '0 : r_slot + AW'(1);
    assign w_last_pos = ((r_pos + CW'(1)) == r_count);
    assign w_key_hit  = (w_rdata == r_key);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_head  <= '0;
            r_count <= '0;
        end else begin
            r_state <= n_state;
            r_head  <= n_head;
            r_count <= n_count;
        end
        r_pos     <= n_pos;
        r_slot    <= n_slot;
        r_key     <= n_key;
        r_status  <= n_status;
        r_out_key <= n_out_key;
    end

    always_comb begin
        n_state   = r_state;
        n_head    = r_head;
        n_count   = r_count;
        n_pos     = r_pos;
        n_slot    = r_slot;
        n_key     = r_key;
        n_status  = r_status;
        n_out_key = r_out_key;
        w_we      = 1'b0;
        w_waddr   = r_slot;
        w_wdata   = r_key;
        w_raddr   = r_slot;
        o_sts     = '0;

        case (r_state)
            ST_IDLE: begin
                o_sts.idle = 1'b1;
                if (i_start) begin
                    n_key     = w_key_wide[KEY_W-1:0];
                    n_status  = STS_OK;
                    n_out_key = '0;
                    n_pos     = '0;
                    n_slot    = r_head;
                    case (i_req.cmd)
                        CMD_DEQUEUE: begin
                            if (r_count == '0) begin
                                n_status = STS_EMPTY;
                                n_state  = ST_FINISH;
                            end else begin
                                n_state = ST_DEQ_RD;
                            end
                        end
                        CMD_PROMOTE: begin
                            if (r_count == '0) begin
                                n_status = STS_NOT_FOUND;
                                n_state  = ST_FINISH;
                            end else begin
                                n_state = ST_SRCH_RD;
                            end
                        end
                        CMD_APPEND: begin
                            if (r_count == CW'(DEPTH)) begin
                                n_status = STS_FULL;
                                n_state  = ST_FINISH;
                            end else begin
                                n_state = ST_APPEND;
                            end
                        end
                        default: begin
                            n_state = ST_FINISH;
                        end
                    endcase
                end
            end
            ST_DEQ_RD: begin
                w_raddr = r_head;
                n_state = ST_DEQ_DATA;
            end
            ST_DEQ_DATA: begin
                n_out_key = w_rd_wide[OUT_KEY_W-1:0];
                n_head    = (r_head == AW'(DEPTH - 1)) ? '0 : r_head + AW'(1);
                n_count   = r_count - CW'(1);
                n_state   = ST_FINISH;
            end
            ST_APPEND: begin
                w_we    = 1'b1;
                w_waddr = w_tail_slot;
                n_count = r_count + CW'(1);
                n_state = ST_FINISH;
            end
            ST_SRCH_RD: begin
                w_raddr = r_slot;
                n_state = ST_SRCH_CMP;
            end
            ST_SRCH_CMP: begin
                if (w_key_hit) begin
                    n_state = ST_MV_RD;
                end else if (w_last_pos) begin
                    n_status = STS_NOT_FOUND;
                    n_state  = ST_FINISH;
                end else begin
                    n_pos   = r_pos + CW'(1);
                    n_slot  = w_slot_inc;
                    n_state = ST_SRCH_RD;
                end
            end
            ST_MV_RD: begin
                // pull the following entry one place towards the head
                w_raddr = w_slot_inc;
                n_state = w_last_pos ? ST_TAIL_WR : ST_MV_WR;
            end
            ST_MV_WR: begin
                w_we    = 1'b1;
                w_waddr = r_slot;
                w_wdata = w_rdata;
                n_slot  = w_slot_inc;
                n_pos   = r_pos + CW'(1);
                n_state = ST_MV_RD;
            end
            ST_TAIL_WR: begin
                w_we    = 1'b1;
                w_waddr = r_slot;
                n_state = ST_FINISH;
            end
            ST_FINISH: begin
                if (i_out_free) begin
                    o_sts.done = 1'b1;
                    n_state    = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    assign o_res.status = r_status;
    assign o_res.key    = r_out_key;
    assign o_res.count  = w_cnt_wide[CNT_OUT_W-1:0];

endmodule

@@ sv/queue_move_to_tail_by_key.sv @@
// Ordered key queue with move-to-tail.
// Input stream (s_axis): one command item per transfer, tdata = cmd, item_key.
//   cmd 0 removes the head, 1 moves the first matching key to the tail,
//   2 appends the key. Result stream (m_axis): exactly one item per command,
//   tdata = status, out_key, entry_count.
// Promote walks the entries one by one through the single read port of the key
//   memory, for the search and for the compaction behind the hit. Rejected
//   commands and the unused code go straight to the result.
// One command is in work at a time; s_axis_tready is high only while the
//   sequencer is idle. A finished result sits in the output register, and the
//   next command is taken while it waits; that command's own result is held
//   back until the receiver has taken the previous one.
// Reset (synchronous, active low) empties the queue and drops any pending
//   result. Key storage is not cleared: entries are only read once written.
module queue_move_to_tail_by_key
    import qmt_pkg::*;
#(
    parameter int DEPTH = 16,
    parameter int KEY_W = 32
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_s_axis_tvalid,
    output logic               o_s_axis_tready,
    input  logic [TDATA_W-1:0] i_s_axis_tdata,  // cmd[1:0], item_key[33:2], zero pad
    output logic               o_m_axis_tvalid,
    input  logic               i_m_axis_tready,
    output logic [TDATA_W-1:0] o_m_axis_tdata   // status[1:0], out_key[33:2],
                                                // entry_count[38:34], zero pad
);

    t_req     w_req;
    t_ctl_sts w_sts;
    t_result  w_res;
    logic     w_start;
    logic     w_out_free;
    logic     r_out_valid;
    t_result  r_out;

    assign w_req.cmd = i_s_axis_tdata[CMD_W-1:0];
    assign w_req.key = i_s_axis_tdata[CMD_W+IN_KEY_W-1:CMD_W];

    assign o_s_axis_tready = w_sts.idle;
    assign w_start         = i_s_axis_tvalid && w_sts.idle;
    assign w_out_free      = !r_out_valid || i_m_axis_tready;

    qmt_ctrl #(
        .DEPTH(DEPTH),
        .KEY_W(KEY_W)
    ) u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (w_start),
        .i_req     (w_req),
        .i_out_free(w_out_free),
        .o_sts     (w_sts),
        .o_res     (w_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_sts.done) begin
            r_out_valid <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
        if (w_sts.done) begin
            r_out <= w_res;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {{(TDATA_W - STATUS_W - OUT_KEY_W - CNT_OUT_W){1'b0}},
                              r_out.count, r_out.key, r_out.status};

endmodule

@@ sv/qmt_chk.sv @@
module qmt_chk
    import qmt_pkg::*;
(
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_s_axis_tvalid,
    input logic               o_s_axis_tready,
    input logic               o_m_axis_tvalid,
    input logic               i_m_axis_tready,
    input logic [TDATA_W-1:0] o_m_axis_tdata
);

    logic [STATUS_W-1:0]  w_status;
    logic [OUT_KEY_W-1:0] w_key;
    logic [CNT_OUT_W-1:0] w_count;

    assign w_status = o_m_axis_tdata[STATUS_W-1:0];
    assign w_key    = o_m_axis_tdata[STATUS_W+OUT_KEY_W-1:STATUS_W];
    assign w_count  = o_m_axis_tdata[STATUS_W+OUT_KEY_W+CNT_OUT_W-1:STATUS_W+OUT_KEY_W];

    // a stalled result stays put
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=> o_m_axis_tvalid && $stable(o_m_axis_tdata))
        else $error("result changed while stalled");

    a_rst_clear: assert property (@(posedge i_clk) !i_rst_n |=> !o_m_axis_tvalid)
        else $error("result valid after reset");

    // one command in work at a time
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_s_axis_tvalid && o_s_axis_tready |=> !o_s_axis_tready)
        else $error("command taken while sequencer busy");

    a_empty_cnt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && w_status == STS_EMPTY |-> w_count == '0)
        else $error("empty status with nonzero count");

    a_key_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && w_status != STS_OK |-> w_key == '0)
        else $error("key returned on failed command");

endmodule

bind queue_move_to_tail_by_key qmt_chk u_qmt_chk (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_s_axis_tvalid(i_s_axis_tvalid),
    .o_s_axis_tready(o_s_axis_tready),
    .o_m_axis_tvalid(o_m_axis_tvalid),
    .i_m_axis_tready(i_m_axis_tready),
    .o_m_axis_tdata (o_m_axis_tdata)
);
